@@ sv/ini_section_command_tokenizer_core_defines.svh @@
// ----------------------------------------------------------------------------
// Assertion macros for the INI section/command tokenizer.
// Every check is sampled on the rising edge of clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef INI_SECTION_COMMAND_TOKENIZER_CORE_DEFINES_SVH
`define INI_SECTION_COMMAND_TOKENIZER_CORE_DEFINES_SVH

// Check that a condition holds at every clock edge.
`define IST_ASSERT(label, cond, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (cond)) \
    else $error(msg);

// Check that an antecedent implies a consequent in the next cycle.
`define IST_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ sv/ist_pkg.sv @@
// ----------------------------------------------------------------------------
// ist_pkg
// Shared types and constants of the INI section/command tokenizer.
// ----------------------------------------------------------------------------
`default_nettype none

package ist_pkg;

  // Width of the internal byte offset and line counters.
  localparam int unsigned POS_WIDTH = 20;
  // Fixed width of the position fields of a result item.
  localparam int unsigned FIELD_W   = 20;

  localparam logic [POS_WIDTH-1:0] POS_MAX = {POS_WIDTH{1'b1}};

  // Characters
  localparam logic [7:0] CH_HASH  = 8'h23;  // '#'
  localparam logic [7:0] CH_LBRK  = 8'h5B;  // '['
  localparam logic [7:0] CH_GT    = 8'h3E;  // '>'
  localparam logic [7:0] CH_RBRK  = 8'h5D;  // ']'
  localparam logic [7:0] CH_NL    = 8'h0A;  // newline
  localparam logic [7:0] CH_TAB   = 8'h09;  // tab
  localparam logic [7:0] CH_SPACE = 8'h20;  // space

  // Event kinds
  localparam logic [2:0] EV_NONE     = 3'd0;
  localparam logic [2:0] EV_SECTION  = 3'd1;
  localparam logic [2:0] EV_COMMAND  = 3'd2;
  localparam logic [2:0] EV_ARGUMENT = 3'd3;
  localparam logic [2:0] EV_ERROR    = 3'd4;

  // Error codes
  localparam logic [2:0] ERR_CMD_OUTSIDE = 3'd0;
  localparam logic [2:0] ERR_NO_LBRK     = 3'd1;
  localparam logic [2:0] ERR_NO_CMD      = 3'd2;
  localparam logic [2:0] ERR_NO_RBRK     = 3'd3;
  localparam logic [2:0] ERR_BAD_GT      = 3'd4;

  typedef struct packed {
    logic [7:0] byte_value;
    logic       new_file;
  } in_item_t;

  typedef struct packed {
    logic [2:0]         event_kind;
    logic [2:0]         error_code;
    logic [FIELD_W-1:0] token_start;
    logic [FIELD_W-1:0] token_length;
    logic [FIELD_W-1:0] line_number;
  } out_item_t;

endpackage

`default_nettype wire

@@ sv/ist_in_if.sv @@
// ----------------------------------------------------------------------------
// ist_in_if
// Valid/ready channel carrying one text byte per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ist_in_if;
  logic              valid;
  logic              ready;
  ist_pkg::in_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/ist_out_if.sv @@
// ----------------------------------------------------------------------------
// ist_out_if
// Valid/ready channel carrying one tokenizer result per item.
// ----------------------------------------------------------------------------
`default_nettype none

interface ist_out_if;
  logic               valid;
  logic               ready;
  ist_pkg::out_item_t data;

  modport source (output valid, output data, input ready);
  modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ sv/ini_section_command_tokenizer_core.sv @@
// ----------------------------------------------------------------------------
// ini_section_command_tokenizer_core
// Byte-wise tokenizer for INI-like text: sections, commands and arguments.
// ----------------------------------------------------------------------------
// Usage:
//   in_i  carries one text byte per item plus a new_file flag that marks the
//         first byte of a file; that byte clears all parse state first.
//   out_o carries exactly one result item per input item: no event, a closed
//         section/command/argument (start offset, length, line) or an error.
//   After an error the block reports no event for every byte until a byte
//   with new_file set arrives.
// Timing:
//   out_o.valid rises once an item has passed the input register and then
//   the parse update that loads the result register. Throughput is 1 item
//   per cycle while out_o is not stalled; the parse state update is a
//   single shallow step from the input register to the result register.
// Reset:
//   rst_ni (async, active low) empties both registers and returns the parse
//   state to idle with offset and line count at zero.
// Backpressure:
//   While out_o is stalled the result holds; one more item may wait in the
//   input register, and in_i.ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

`include "ini_section_command_tokenizer_core_defines.svh"

module ini_section_command_tokenizer_core (
  input  wire          clk_i,
  input  wire          rst_ni,
  ist_in_if.sink       in_i,
  ist_out_if.source    out_o
);

  localparam int unsigned PW = ist_pkg::POS_WIDTH;
  localparam int unsigned FW = ist_pkg::FIELD_W;

  typedef enum logic [2:0] {
    MODE_IDLE,
    MODE_COMMENT,
    MODE_SECTION,
    MODE_COMMAND,
    MODE_ARGUMENT
  } mode_e;

  // Input stage
  logic              s1_valid_q;
  ist_pkg::in_item_t s1_item_q;

  // Output stage
  logic               out_valid_q;
  ist_pkg::out_item_t out_item_q;
  ist_pkg::out_item_t res;

  // Parse state
  mode_e           mode_q, mode_d;
  logic            sec_seen_q, sec_seen_d;
  logic            cmd_seen_q, cmd_seen_d;
  logic            tok_open_q, tok_open_d;
  logic [PW-1:0]   tok_start_q, tok_start_d;
  logic [PW-1:0]   offset_q, offset_d;
  logic [PW-1:0]   line_q, line_d;
  logic            halted_q, halted_d;

  // State after an optional new-file clear
  mode_e           mode_e0;
  logic            sec_seen_e, cmd_seen_e, tok_open_e, halted_e;
  logic [PW-1:0]   tok_start_e, offset_e, line_e;

  logic            out_free;
  logic            s1_fire;
  logic            in_fire;
  logic [7:0]      ch;
  logic [PW-1:0]   close_start;
  logic [PW-1:0]   close_len;
  logic            report_line;

  // Advance the result register when it is empty or being taken.
  assign out_free   = !out_valid_q || out_o.ready;
  assign s1_fire    = s1_valid_q && out_free;
  assign in_i.ready = !s1_valid_q || out_free;
  assign in_fire    = in_i.valid && in_i.ready;

  assign out_o.valid = out_valid_q;
  assign out_o.data  = out_item_q;

  assign ch = s1_item_q.byte_value;

  // Drop all parse state on the first byte of a new file.
  always_comb begin
    if (s1_item_q.new_file) begin
      mode_e0     = MODE_IDLE;
      sec_seen_e  = 1'b0;
      cmd_seen_e  = 1'b0;
      tok_open_e  = 1'b0;
      tok_start_e = '0;
      offset_e    = '0;
      line_e      = '0;
      halted_e    = 1'b0;
    end else begin
      mode_e0     = mode_q;
      sec_seen_e  = sec_seen_q;
      cmd_seen_e  = cmd_seen_q;
      tok_open_e  = tok_open_q;
      tok_start_e = tok_start_q;
      offset_e    = offset_q;
      line_e      = line_q;
      halted_e    = halted_q;
    end
  end

  // Start and length of a token closed at the current offset; an empty
  // token reports the closing offset and length zero.
  always_comb begin
    if (tok_open_e && (tok_start_e <= offset_e)) begin
      close_start = tok_start_e;
      close_len   = offset_e - tok_start_e;
    end else begin
      close_start = offset_e;
      close_len   = '0;
    end
  end

  // One parse step per byte.
  always_comb begin
    mode_d      = mode_e0;
    sec_seen_d  = sec_seen_e;
    cmd_seen_d  = cmd_seen_e;
    tok_open_d  = tok_open_e;
    tok_start_d = tok_start_e;
    offset_d    = offset_e;
    line_d      = line_e;
    halted_d    = halted_e;
    res         = '0;
    report_line = 1'b0;

    if (!halted_e) begin
      // Count lines on every newline, saturating.
      if (ch == ist_pkg::CH_NL && line_e != ist_pkg::POS_MAX) begin
        line_d = line_e + 1'b1;
      end

      case (mode_e0)
        MODE_COMMENT: begin
          if (ch == ist_pkg::CH_NL) begin
            mode_d = MODE_IDLE;
          end
        end
        MODE_SECTION: begin
          if (ch == ist_pkg::CH_NL) begin
            halted_d       = 1'b1;
            res.event_kind = ist_pkg::EV_ERROR;
            res.error_code = ist_pkg::ERR_NO_RBRK;
            report_line    = 1'b1;
          end else if (ch == ist_pkg::CH_RBRK) begin
            tok_open_d       = 1'b0;
            res.event_kind   = ist_pkg::EV_SECTION;
            res.token_start  = FW'(close_start);
            res.token_length = FW'(close_len);
            report_line      = 1'b1;
            sec_seen_d       = 1'b1;
            mode_d           = MODE_IDLE;
          end else if (!tok_open_e) begin
            tok_open_d  = 1'b1;
            tok_start_d = offset_e;
          end
        end
        MODE_COMMAND: begin
          if (ch == ist_pkg::CH_NL || ch == ist_pkg::CH_SPACE || ch == ist_pkg::CH_TAB) begin
            tok_open_d       = 1'b0;
            res.event_kind   = ist_pkg::EV_COMMAND;
            res.token_start  = FW'(close_start);
            res.token_length = FW'(close_len);
            report_line      = 1'b1;
            cmd_seen_d       = 1'b1;
            mode_d           = MODE_IDLE;
          end else if (ch == ist_pkg::CH_GT) begin
            halted_d       = 1'b1;
            res.event_kind = ist_pkg::EV_ERROR;
            res.error_code = ist_pkg::ERR_BAD_GT;
            report_line    = 1'b1;
          end else if (!tok_open_e) begin
            tok_open_d  = 1'b1;
            tok_start_d = offset_e;
          end
        end
        MODE_ARGUMENT: begin
          if (ch == ist_pkg::CH_NL || ch == ist_pkg::CH_HASH) begin
            tok_open_d       = 1'b0;
            res.event_kind   = ist_pkg::EV_ARGUMENT;
            res.token_start  = FW'(close_start);
            res.token_length = FW'(close_len);
            report_line      = 1'b1;
            mode_d           = (ch == ist_pkg::CH_NL) ? MODE_IDLE : MODE_COMMENT;
          end else if (ch == ist_pkg::CH_LBRK) begin
            if (!tok_open_e) begin
              mode_d = MODE_SECTION;
            end
          end else if (ch == ist_pkg::CH_GT) begin
            if (!tok_open_e) begin
              mode_d = MODE_COMMAND;
            end
          end
        end
        default: begin
          // Idle, and any unused code, behaves as idle.
          mode_d = MODE_IDLE;
          if (ch == ist_pkg::CH_HASH) begin
            mode_d = MODE_COMMENT;
          end else if (ch == ist_pkg::CH_LBRK) begin
            mode_d = MODE_SECTION;
          end else if (ch == ist_pkg::CH_GT) begin
            if (!sec_seen_e) begin
              halted_d       = 1'b1;
              res.event_kind = ist_pkg::EV_ERROR;
              res.error_code = ist_pkg::ERR_CMD_OUTSIDE;
              report_line    = 1'b1;
            end else begin
              mode_d = MODE_COMMAND;
            end
          end else if (ch == ist_pkg::CH_NL || ch == ist_pkg::CH_TAB ||
                       ch == ist_pkg::CH_SPACE) begin
            // Skip blanks; newline was counted above.
          end else if (!sec_seen_e) begin
            halted_d       = 1'b1;
            res.event_kind = ist_pkg::EV_ERROR;
            res.error_code = ist_pkg::ERR_NO_LBRK;
            report_line    = 1'b1;
          end else if (!cmd_seen_e) begin
            halted_d       = 1'b1;
            res.event_kind = ist_pkg::EV_ERROR;
            res.error_code = ist_pkg::ERR_NO_CMD;
            report_line    = 1'b1;
          end else begin
            mode_d      = MODE_ARGUMENT;
            tok_open_d  = 1'b1;
            tok_start_d = offset_e;
          end
        end
      endcase

      if (report_line) begin
        res.line_number = FW'(line_d);
      end

      // Advance the byte offset, saturating.
      if (offset_e != ist_pkg::POS_MAX) begin
        offset_d = offset_e + 1'b1;
      end
    end
  end

  // Hold state and registered outputs.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      s1_item_q   <= '0;
      out_valid_q <= 1'b0;
      out_item_q  <= '0;
      mode_q      <= MODE_IDLE;
      sec_seen_q  <= 1'b0;
      cmd_seen_q  <= 1'b0;
      tok_open_q  <= 1'b0;
      tok_start_q <= '0;
      offset_q    <= '0;
      line_q      <= '0;
      halted_q    <= 1'b0;
    end else begin
      if (in_fire) begin
        s1_valid_q <= 1'b1;
        s1_item_q  <= in_i.data;
      end else if (s1_fire) begin
        s1_valid_q <= 1'b0;
      end

      if (s1_fire) begin
        out_valid_q <= 1'b1;
        out_item_q  <= res;
        mode_q      <= mode_d;
        sec_seen_q  <= sec_seen_d;
        cmd_seen_q  <= cmd_seen_d;
        tok_open_q  <= tok_open_d;
        tok_start_q <= tok_start_d;
        offset_q    <= offset_d;
        line_q      <= line_d;
        halted_q    <= halted_d;
      end else if (out_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // A halted block reports nothing until a new file starts.
  `IST_ASSERT_NEXT(a_halt_silent, s1_fire && halted_q && !s1_item_q.new_file,
                   out_item_q.event_kind == ist_pkg::EV_NONE, "halted block emitted an event")

  // Every error halts the block.
  `IST_ASSERT_NEXT(a_error_halts, s1_fire && res.event_kind == ist_pkg::EV_ERROR,
                   halted_q, "error did not halt the block")

  // The byte offset never moves backward within a file.
  `IST_ASSERT_NEXT(a_offset_mono, s1_fire && !s1_item_q.new_file,
                   offset_q >= $past(offset_q), "byte offset moved backward")

  // A result with no event carries all-zero position fields.
  `IST_ASSERT(a_none_zero, !out_valid_q || out_item_q.event_kind != ist_pkg::EV_NONE ||
              (out_item_q.token_start == '0 && out_item_q.token_length == '0 &&
               out_item_q.line_number == '0), "empty result carries position data")

endmodule

`default_nettype wire

@@ tb/ini_section_command_tokenizer_core_tb.sv @@
// ----------------------------------------------------------------------------
// ini_section_command_tokenizer_core_tb
// Drives text bytes into the tokenizer, mirrors the parse state in a
// scoreboard and compares every result item field by field, in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ini_section_command_tokenizer_core_tb;

  localparam int PW = ist_pkg::POS_WIDTH;
  localparam int FW = ist_pkg::FIELD_W;

  // Input items to feed before stopping
  localparam int ITEM_TARGET   = 1250;
  // Stop idling on both sides for the last stretch of the run
  localparam int CALM_ITEMS    = 150;
  // Long receiver hold-off that backs the block up into its input
  localparam int HOLD_CYCLES   = 64;
  localparam int HOLD_AT_ITEM  = 300;
  // Cycles without any handshake before the run is declared hung
  localparam int WATCHDOG_MAX  = 1000;
  // Input register plus result register
  localparam int DRAIN_CYCLES  = 8;
  localparam int REPORT_LIMIT  = 10;

  typedef enum logic [2:0] {
    PM_IDLE,
    PM_COMMENT,
    PM_SECTION,
    PM_COMMAND,
    PM_ARGUMENT
  } parse_mode_e;

  // --------------------------------------------------------------------------
  // Parse-state mirror and queue of expected result items
  // --------------------------------------------------------------------------
  class token_scoreboard;
    parse_mode_e          mode;
    bit                   section_seen;
    bit                   command_seen;
    bit                   token_open;
    bit                   halted;
    logic [PW-1:0]        tok_start;
    logic [PW-1:0]        offset;
    logic [PW-1:0]        lines;
    ist_pkg::out_item_t   token_q[$];
    int                   item_count;
    int                   mismatches;

    function new();
      clear_state();
      item_count = 0;
      mismatches = 0;
    endfunction

    function void clear_state();
      mode         = PM_IDLE;
      section_seen = 1'b0;
      command_seen = 1'b0;
      token_open   = 1'b0;
      halted       = 1'b0;
      tok_start    = '0;
      offset       = '0;
      lines        = '0;
    endfunction

    function void bump_line();
      if (lines != ist_pkg::POS_MAX) lines++;
    endfunction

    function void open_token(logic [PW-1:0] pos);
      if (!token_open) begin
        token_open = 1'b1;
        tok_start  = pos;
      end
    endfunction

    // An empty token reports the closing byte's offset with length zero
    function void close_token(logic [PW-1:0] pos, logic [2:0] kind,
                              inout ist_pkg::out_item_t r);
      logic [PW-1:0] start;
      logic [PW-1:0] len;
      start = pos;
      len   = '0;
      if (token_open && tok_start <= pos) begin
        start = tok_start;
        len   = pos - tok_start;
      end
      token_open     = 1'b0;
      r.event_kind   = kind;
      r.token_start  = FW'(start);
      r.token_length = FW'(len);
      r.line_number  = FW'(lines);
    endfunction

    function void raise_error(logic [2:0] code, inout ist_pkg::out_item_t r);
      halted        = 1'b1;
      r.event_kind  = ist_pkg::EV_ERROR;
      r.error_code  = code;
      r.line_number = FW'(lines);
    endfunction

    // Advance the mirror by one accepted byte and queue the result it causes
    function void note_input(ist_pkg::in_item_t it);
      ist_pkg::out_item_t r;
      logic [7:0]         ch;
      logic [PW-1:0]      pos;
      ch = it.byte_value;
      r  = '0;
      item_count++;
      if (it.new_file) clear_state();
      if (halted) begin
        token_q.push_back(r);
        return;
      end
      pos = offset;
      case (mode)
        PM_COMMENT: begin
          if (ch == ist_pkg::CH_NL) begin
            bump_line();
            mode = PM_IDLE;
          end
        end
        PM_SECTION: begin
          if (ch == ist_pkg::CH_NL) begin
            bump_line();
            raise_error(ist_pkg::ERR_NO_RBRK, r);
          end else if (ch == ist_pkg::CH_RBRK) begin
            close_token(pos, ist_pkg::EV_SECTION, r);
            section_seen = 1'b1;
            mode         = PM_IDLE;
          end else begin
            open_token(pos);
          end
        end
        PM_COMMAND: begin
          if (ch == ist_pkg::CH_NL || ch == ist_pkg::CH_SPACE || ch == ist_pkg::CH_TAB) begin
            if (ch == ist_pkg::CH_NL) bump_line();
            close_token(pos, ist_pkg::EV_COMMAND, r);
            command_seen = 1'b1;
            mode         = PM_IDLE;
          end else if (ch == ist_pkg::CH_GT) begin
            raise_error(ist_pkg::ERR_BAD_GT, r);
          end else begin
            open_token(pos);
          end
        end
        PM_ARGUMENT: begin
          if (ch == ist_pkg::CH_NL || ch == ist_pkg::CH_HASH) begin
            if (ch == ist_pkg::CH_NL) bump_line();
            close_token(pos, ist_pkg::EV_ARGUMENT, r);
            mode = (ch == ist_pkg::CH_NL) ? PM_IDLE : PM_COMMENT;
          end else if (ch == ist_pkg::CH_LBRK) begin
            if (!token_open) mode = PM_SECTION;
          end else if (ch == ist_pkg::CH_GT) begin
            if (!token_open) mode = PM_COMMAND;
          end
        end
        default: begin
          mode = PM_IDLE;
          if (ch == ist_pkg::CH_HASH) begin
            mode = PM_COMMENT;
          end else if (ch == ist_pkg::CH_LBRK) begin
            mode = PM_SECTION;
          end else if (ch == ist_pkg::CH_GT) begin
            if (!section_seen) raise_error(ist_pkg::ERR_CMD_OUTSIDE, r);
            else mode = PM_COMMAND;
          end else if (ch == ist_pkg::CH_NL) begin
            bump_line();
          end else if (ch == ist_pkg::CH_TAB || ch == ist_pkg::CH_SPACE) begin
            // whitespace between tokens is skipped
          end else if (!section_seen) begin
            raise_error(ist_pkg::ERR_NO_LBRK, r);
          end else if (!command_seen) begin
            raise_error(ist_pkg::ERR_NO_CMD, r);
          end else begin
            mode       = PM_ARGUMENT;
            token_open = 1'b1;
            tok_start  = pos;
          end
        end
      endcase
      if (offset != ist_pkg::POS_MAX) offset++;
      token_q.push_back(r);
    endfunction

    function void check_result(ist_pkg::out_item_t got);
      ist_pkg::out_item_t exp;
      if (token_q.size() == 0) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT)
          $display("%0t: unexpected result: kind %0d code %0d start %0d len %0d line %0d",
                   $realtime, got.event_kind, got.error_code, got.token_start,
                   got.token_length, got.line_number);
        return;
      end
      exp = token_q.pop_front();
      if (got.event_kind !== exp.event_kind || got.error_code !== exp.error_code ||
          got.token_start !== exp.token_start || got.token_length !== exp.token_length ||
          got.line_number !== exp.line_number) begin
        mismatches++;
        if (mismatches <= REPORT_LIMIT) begin
          $display("%0t: result mismatch", $realtime);
          $display("  expected kind %0d code %0d start %0d len %0d line %0d",
                   exp.event_kind, exp.error_code, exp.token_start, exp.token_length,
                   exp.line_number);
          $display("  actual   kind %0d code %0d start %0d len %0d line %0d",
                   got.event_kind, got.error_code, got.token_start, got.token_length,
                   got.line_number);
        end
      end
    endfunction

    function int pending();
      return token_q.size();
    endfunction
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels and the block
  // --------------------------------------------------------------------------
  logic clk_i = 1'b0;
  logic rst_ni;

  ist_in_if  in_if ();
  ist_out_if out_if ();

  ini_section_command_tokenizer_core i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_if),
    .out_o  (out_if)
  );

  token_scoreboard sb = new();

  // Idle controls: the sender's gap rate changes per file, calm turns all idling off
  int gap_pct  = 20;
  bit calm     = 1'b0;
  bit next_nf  = 1'b1;
  ist_pkg::in_item_t line_q[$];

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // --------------------------------------------------------------------------
  // Sender side
  // --------------------------------------------------------------------------

  // Offer one byte, hold it until accepted, then note it in the scoreboard
  task automatic send_byte(input logic [7:0] b, input logic nf);
    ist_pkg::in_item_t it;
    it.byte_value = b;
    it.new_file   = nf;
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      in_if.valid <= 1'b0;
      repeat ($urandom_range(1, 17)) @(posedge clk_i);
    end
    in_if.valid <= 1'b1;
    in_if.data  <= it;
    @(posedge clk_i);
    while (!in_if.ready) @(posedge clk_i);
    sb.note_input(it);
  endtask

  // Send a string; the first character optionally starts a new file
  task automatic send_text(input string s, input logic first_nf);
    for (int k = 0; k < s.len(); k++) send_byte(s[k], first_nf && k == 0);
  endtask

  // Append one byte to the pending line, carrying a queued new-file mark
  function automatic void push_byte(logic [7:0] b);
    ist_pkg::in_item_t it;
    it.byte_value = b;
    it.new_file   = next_nf;
    next_nf       = 1'b0;
    line_q.push_back(it);
  endfunction

  // Mostly printable name characters, sometimes any byte at all
  function automatic logic [7:0] name_char();
    if ($urandom_range(0, 9) == 0) return 8'($urandom_range(0, 255));
    return 8'($urandom_range(33, 126));
  endfunction

  function automatic int name_len();
    if ($urandom_range(0, 19) == 0) return $urandom_range(20, 40);
    return $urandom_range(0, 6);
  endfunction

  function automatic void push_blanks();
    repeat ($urandom_range(0, 2))
      push_byte($urandom_range(0, 1) ? ist_pkg::CH_SPACE : ist_pkg::CH_TAB);
  endfunction

  // Argument text up to the end of line, closed by newline or a trailing comment
  function automatic void push_argument();
    logic [7:0] c;
    push_byte(8'($urandom_range(33, 126)));
    repeat (name_len()) begin
      c = name_char();
      if (c == ist_pkg::CH_NL || c == ist_pkg::CH_HASH) c = ist_pkg::CH_SPACE;
      push_byte(c);
    end
    if ($urandom_range(0, 3) == 0) begin
      push_byte(ist_pkg::CH_HASH);
      repeat ($urandom_range(0, 4)) push_byte(name_char());
    end
    push_byte(ist_pkg::CH_NL);
  endfunction

  // Build one line: mostly well-formed text with random content, some noise
  function automatic void build_line();
    int pick;
    pick = $urandom_range(0, 99);
    if (pick < 10) begin
      next_nf = 1'b1;
      case ($urandom_range(0, 2))
        0: gap_pct = 0;
        1: gap_pct = 8;
        default: gap_pct = 35;
      endcase
    end
    if (pick < 25) begin
      push_blanks();
      push_byte(ist_pkg::CH_LBRK);
      repeat (name_len()) push_byte(name_char());
      push_byte(ist_pkg::CH_RBRK);
      push_blanks();
      push_byte(ist_pkg::CH_NL);
    end else if (pick < 52) begin
      push_blanks();
      push_byte(ist_pkg::CH_GT);
      repeat (name_len()) push_byte(name_char());
      case ($urandom_range(0, 2))
        0: push_byte(ist_pkg::CH_NL);
        1: begin
          push_byte(ist_pkg::CH_SPACE);
          if ($urandom_range(0, 9) < 7) push_argument();
          else push_byte(ist_pkg::CH_NL);
        end
        default: begin
          push_byte(ist_pkg::CH_TAB);
          push_blanks();
          push_argument();
        end
      endcase
    end else if (pick < 78) begin
      push_argument();
    end else if (pick < 88) begin
      push_blanks();
      if ($urandom_range(0, 1)) begin
        push_byte(ist_pkg::CH_HASH);
        repeat ($urandom_range(0, 8)) push_byte(8'($urandom_range(0, 255)));
      end
      push_byte(ist_pkg::CH_NL);
    end else begin
      repeat ($urandom_range(1, 6)) push_byte(8'($urandom_range(0, 255)));
    end
  endfunction

  // --------------------------------------------------------------------------
  // Receiver side: random stall bursts, one long hold-off to back up the input
  // --------------------------------------------------------------------------
  initial begin
    int stall_pct;
    int cyc;
    bit held;
    stall_pct = 10;
    cyc       = 0;
    held      = 1'b0;
    out_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(posedge clk_i);
      cyc++;
      if (cyc % 128 == 0) begin
        case ($urandom_range(0, 2))
          0: stall_pct = 0;
          1: stall_pct = 8;
          default: stall_pct = 35;
        endcase
      end
      if (!held && sb.item_count >= HOLD_AT_ITEM) begin
        // hold off long enough for both internal registers to fill
        held = 1'b1;
        out_if.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end else if (!calm && $urandom_range(0, 99) < stall_pct) begin
        out_if.ready <= 1'b0;
        repeat ($urandom_range(1, 17)) @(posedge clk_i);
      end
      out_if.ready <= 1'b1;
    end
  end

  // --------------------------------------------------------------------------
  // Result checking and watchdog
  // --------------------------------------------------------------------------
  int quiet_cycles = 0;

  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (out_if.valid && out_if.ready) sb.check_result(out_if.data);
      if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles + 1 >= WATCHDOG_MAX) begin
        $display("timeout: no item moved for %0d cycles", WATCHDOG_MAX);
        $display("TB_ERROR");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Main sequence
  // --------------------------------------------------------------------------
  initial begin
    in_if.valid <= 1'b0;
    in_if.data  <= '0;
    rst_ni      <= 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty section and command, byte 0xFF as an argument closed by
    // a comment, brackets inside an argument, '>' inside a command name,
    // a byte swallowed while halted
    send_text("[]> ", 1'b1);
    send_byte(8'hFF, 1'b0);
    send_text("#\nx[>\n\t>>", 1'b0);
    send_byte(8'h00, 1'b0);
    // Command before any section
    send_text(">", 1'b1);
    // Stray byte 0x00 where a section header belongs
    send_byte(8'h00, 1'b1);
    // Section header cut by newline
    send_text("[x\n", 1'b1);
    // Text after a section but before any command
    send_text("[]q", 1'b1);

    // Random files, line by line
    next_nf = 1'b1;
    while (sb.item_count < ITEM_TARGET) begin
      if (sb.item_count >= ITEM_TARGET - CALM_ITEMS) calm = 1'b1;
      build_line();
      while (line_q.size() != 0) begin
        ist_pkg::in_item_t it;
        it = line_q.pop_front();
        send_byte(it.byte_value, it.new_file);
      end
    end
    in_if.valid <= 1'b0;

    // Drain: wait for every expected result, then a few more cycles
    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0 && sb.pending() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule
